/* design/lsde_pkg.sv */
// Shared types, constants and helper functions for the LRU stack-distance engine.
// Has no dependencies; the cell, segment encoder and top-level files import it.
package lsde_pkg;

  // Page key width and the width of the reported stack depth.
  localparam int KEY_W        = 63;
  localparam int DEPTH_OUT_W  = 10;
  localparam int DEPTH_SAT    = 1023;
  localparam int STACK_DEPTH_DEF = 1024;

  // Width of one search segment; the local encoder handles this many cells.
  localparam int SEG_W_MAX = 32;
  localparam int SEG_LOC_W = 5;

  // Packed stream widths.
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 16;

  // Sequencer states for one access.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_SEG,
    ST_ENC,
    ST_UPD
  } lsde_state_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic live;  // cell holds a valid entry (below occupancy)
    logic ld;    // cell takes its load key this cycle
  } lsde_cell_ctl_t;

  // One-hot (at most one bit set) to binary index over a segment.
  function automatic logic [SEG_LOC_W-1:0] lsde_enc32(input logic [SEG_W_MAX-1:0] v);
    logic [SEG_LOC_W-1:0] r;
    r = '0;
    for (int i = 0; i < SEG_W_MAX; i++) begin
      if (v[i]) begin
        r = r | SEG_LOC_W'(i);
      end
    end
    return r;
  endfunction

endpackage

/* design/lsde_cell.sv */
// One stack cell: holds a page key, compares it against the searched key and
// loads either the new key or its upper neighbor's key. Depends on lsde_pkg.
module lsde_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lsde_pkg::lsde_cell_ctl_t ctl_i,
  input  logic [lsde_pkg::KEY_W-1:0] cmp_key_i,
  input  logic [lsde_pkg::KEY_W-1:0] d_key_i,
  output logic [lsde_pkg::KEY_W-1:0] key_o,
  output logic                    match_o
);
  import lsde_pkg::*;

  logic [KEY_W-1:0] key_r;
  logic             match_r;
  logic             match_nxt;

  // A cell above the occupancy line never reports a match.
  assign match_nxt = ctl_i.live && (key_r == cmp_key_i);

  // Stored key moves only when the sequencer shifts this cell.
  always_ff @(posedge clk) begin
    if (ctl_i.ld) begin
      key_r <= d_key_i;
    end
  end

  // Registered compare result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  assign key_o   = key_r;
  assign match_o = match_r;

endmodule

/* design/lsde_seg.sv */
// Segment encoder: folds a group of cell match bits into a registered hit flag
// and local binary index. Depends on lsde_pkg for the encode function.
module lsde_seg #(
  parameter int SEG_W = lsde_pkg::SEG_W_MAX
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [SEG_W-1:0]         match_i,
  output logic                     hit_o,
  output logic [$clog2(SEG_W)-1:0] loc_o
);
  import lsde_pkg::*;

  localparam int LOC_W = $clog2(SEG_W);

  logic                 hit_r;
  logic [LOC_W-1:0]     loc_r;
  logic [SEG_LOC_W-1:0] loc_full;

  // At most one key in the stack can match, so an OR encoder is exact.
  assign loc_full = lsde_enc32(SEG_W_MAX'(match_i));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= |match_i;
    end
  end

  always_ff @(posedge clk) begin
    loc_r <= loc_full[LOC_W-1:0];
  end

  assign hit_o = hit_r;
  assign loc_o = loc_r;

endmodule

/* design/lru_stack_distance_engine_unit.sv */
// Top level of the LRU stack-distance engine: cell chain, segment encoders,
// access sequencer and result register. Depends on lsde_pkg, lsde_cell, lsde_seg.
//
//  Channel | Direction | Handshake           | Payload
//  in_     | input     | in_tvalid/in_tready  | tdata: page_key; tuser: reaccess
//  out_    | output    | out_tvalid/out_tready| tdata: hit, stack_depth, error, overflow
//
// Each access steps through accept, compare in every cell, segment encode,
// final encode across segments, then the chain update and result load.
// The sequencer takes one access at a time and walks its five states for each.
// A stalled result holds the update step until the output register frees up.
// Reset clears occupancy, the sequencer and the output valid; cell keys are not
// cleared, since only entries below occupancy are ever compared.
module lru_stack_distance_engine_unit #(
  parameter int STACK_DEPTH = lsde_pkg::STACK_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lsde_pkg::IN_TDATA_W-1:0]  in_tdata,   // [62:0] page_key, [63] zero
  input  logic                             in_tuser,   // [0] reaccess
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] hit, [10:1] stack_depth, [11] error, [12] overflow, [15:13] zero
  output logic [lsde_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import lsde_pkg::*;

  localparam int IDX_W = $clog2(STACK_DEPTH);
  localparam int OCC_W = $clog2(STACK_DEPTH + 1);
  localparam int SEG_W = (STACK_DEPTH < SEG_W_MAX) ? STACK_DEPTH : SEG_W_MAX;
  localparam int NSEG  = (STACK_DEPTH + SEG_W - 1) / SEG_W;
  localparam int LOC_W = $clog2(SEG_W);

  // Sequencer.
  lsde_state_t state_r, state_nxt;
  logic        accept;
  logic        enc_en;
  logic        upd_go;

  // Access registers.
  logic [KEY_W-1:0] key_r;
  logic             flag_r;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic             occ_full;

  // Encode results.
  logic [IDX_W-1:0] pos_r, pos_cmb;
  logic             found_r, found_cmb;
  logic [IDX_W-1:0] shift_lim_r, shift_lim_cmb;
  logic             do_upd_r;

  // Cell chain and segment signals.
  logic [KEY_W-1:0]         stk_key [STACK_DEPTH];
  logic [STACK_DEPTH-1:0]   match_vec;
  logic [NSEG*SEG_W-1:0]    match_pad;
  logic [NSEG-1:0]          seg_hit;
  logic [LOC_W-1:0]         seg_loc [NSEG];
  logic [STACK_DEPTH-1:0]   cell_ld;
  lsde_cell_ctl_t           cell_ctl [STACK_DEPTH];

  // Result register.
  logic                   out_vld_r, out_vld_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                   res_hit, res_err, res_ovf;
  logic [DEPTH_OUT_W-1:0] res_depth;

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: state_nxt = ST_SEG;
      ST_SEG: state_nxt = ST_ENC;
      ST_ENC: state_nxt = ST_UPD;
      ST_UPD: begin
        if (!out_vld_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output decode of the sequencer.
  always_comb begin
    in_tready = 1'b0;
    enc_en    = 1'b0;
    upd_go    = 1'b0;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_ENC:  enc_en    = 1'b1;
      ST_UPD:  upd_go    = !out_vld_r || out_tready;
      default: ;
    endcase
  end

  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Latch the access on its transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      key_r  <= in_tdata[KEY_W-1:0];
      flag_r <= in_tuser;
    end
  end

  // Cell chain: cell 0 is the most recent entry.
  for (genvar gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
    if (gi == 0) begin : g_top
      assign cell_ld[gi] = upd_go && do_upd_r;
      lsde_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_i     (cell_ctl[gi]),
        .cmp_key_i (key_r),
        .d_key_i   (key_r),
        .key_o     (stk_key[gi]),
        .match_o   (match_vec[gi])
      );
    end else begin : g_body
      assign cell_ld[gi] = upd_go && do_upd_r && (IDX_W'(gi) <= shift_lim_r);
      lsde_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_i     (cell_ctl[gi]),
        .cmp_key_i (key_r),
        .d_key_i   (stk_key[gi-1]),
        .key_o     (stk_key[gi]),
        .match_o   (match_vec[gi])
      );
    end
    assign cell_ctl[gi] = '{live: (OCC_W'(gi) < occ_r), ld: cell_ld[gi]};
  end

  // Segment encoders over the match bits, padded to whole segments.
  assign match_pad = (NSEG*SEG_W)'(match_vec);

  for (genvar gs = 0; gs < NSEG; gs++) begin : g_seg
    lsde_seg #(.SEG_W(SEG_W)) u_seg (
      .clk     (clk),
      .rst_n   (rst_n),
      .match_i (match_pad[gs*SEG_W +: SEG_W]),
      .hit_o   (seg_hit[gs]),
      .loc_o   (seg_loc[gs])
    );
  end

  // Final encode across segments and the extent of the shift.
  assign occ_full = (occ_r == OCC_W'(STACK_DEPTH));

  always_comb begin
    pos_cmb = '0;
    for (int s = 0; s < NSEG; s++) begin
      if (seg_hit[s]) begin
        pos_cmb = pos_cmb | (IDX_W'(s * SEG_W) + IDX_W'(seg_loc[s]));
      end
    end
    found_cmb = |seg_hit;
    if (found_cmb) begin
      shift_lim_cmb = pos_cmb;
    end else if (occ_full) begin
      shift_lim_cmb = IDX_W'(STACK_DEPTH - 1);
    end else begin
      shift_lim_cmb = IDX_W'(occ_r);
    end
  end

  always_ff @(posedge clk) begin
    if (enc_en) begin
      pos_r       <= pos_cmb;
      found_r     <= found_cmb;
      shift_lim_r <= shift_lim_cmb;
      do_upd_r    <= !found_cmb || flag_r;
    end
  end

  // Occupancy grows on a miss until the stack is full.
  always_comb begin
    occ_nxt = occ_r;
    if (upd_go && !found_r && !occ_full) begin
      occ_nxt = occ_r + OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // Result fields; a deep hit saturates the reported depth.
  always_comb begin
    res_hit = found_r;
    res_err = !found_r && flag_r;
    res_ovf = !found_r && occ_full;
    if (!found_r) begin
      res_depth = '0;
    end else if (32'(pos_r) > DEPTH_SAT) begin
      res_depth = DEPTH_OUT_W'(DEPTH_SAT);
    end else begin
      res_depth = DEPTH_OUT_W'(pos_r);
    end
    out_data_nxt = OUT_TDATA_W'({res_ovf, res_err, res_depth, res_hit});
  end

  // Output register: loaded by the update step, cleared on its transfer.
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (upd_go) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

/* design/lsde_chk.sv */
// Port-level checker for the LRU stack-distance engine, bound to the top level.
// Depends only on the top level's port list.
module lsde_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // Reset empties the result register.
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A stalled result keeps its data.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // A hit never reports error or overflow.
  a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> !out_tdata[11] && !out_tdata[12])
    else $error("hit with error or overflow");

  // A miss reports depth zero.
  a_miss_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[10:1] == 10'd0)
    else $error("miss with nonzero depth");

  // One access at a time: no transfer right after a transfer.
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after a transfer");

endmodule

bind lru_stack_distance_engine_unit lsde_chk u_lsde_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
